// ===== sv/dmx_pm_pkg.sv =====
// shared types and constants for the dmx pixel mapper
// no dependencies; imported by every module of the block

package dmx_pm_pkg;

  // pixel store size; led_count saturates here
  localparam int MAX_PIXELS = 512;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // register indexes on the configuration port (byte address = 4 * index)
  localparam logic [1:0] REG_STRIP_ENABLED = 2'd0;
  localparam logic [1:0] REG_MODE          = 2'd1;
  localparam logic [1:0] REG_LED_COUNT     = 2'd2;
  localparam logic [1:0] REG_GROUP_SIZE    = 2'd3;

  typedef enum logic [1:0] {
    MODE_PIXEL  = 2'd0,
    MODE_GROUP  = 2'd1,
    MODE_BAR    = 2'd2,
    MODE_IGNORE = 2'd3
  } mode_t;

  typedef struct packed {
    logic       strip_enabled;
    mode_t      mode;
    logic [9:0] led_count;
    logic [7:0] group_size;
  } cfg_t;

  typedef struct packed {
    logic [7:0] channel_byte;
    logic       frame_start;
  } byte_item_t;

  typedef struct packed {
    logic [8:0] start_index;
    logic [9:0] pixel_count;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } write_item_t;

  // one complete colour triple and where it sits in the frame
  typedef struct packed {
    logic [9:0] index;
    logic       first;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } triple_t;

endpackage

// ===== sv/dmx_pm_regs.sv =====
// configuration register file on an apb-style port
// depends on dmx_pm_pkg

module dmx_pm_regs
  import dmx_pm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strip_enabled <= 1'b0;
      cfg.mode          <= MODE_PIXEL;
      cfg.led_count     <= 10'd0;
      cfg.group_size    <= 8'd1;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_STRIP_ENABLED: cfg.strip_enabled <= pwdata[0];
        REG_MODE:          cfg.mode          <= mode_t'(pwdata[1:0]);
        REG_LED_COUNT:     cfg.led_count     <= pwdata[9:0];
        REG_GROUP_SIZE:    cfg.group_size    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_STRIP_ENABLED: prdata = {{(DATA_W-1){1'b0}}, cfg.strip_enabled};
      REG_MODE:          prdata = {{(DATA_W-2){1'b0}}, cfg.mode};
      REG_LED_COUNT:     prdata = {{(DATA_W-10){1'b0}}, cfg.led_count};
      REG_GROUP_SIZE:    prdata = {{(DATA_W-8){1'b0}}, cfg.group_size};
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== sv/dmx_pm_assembler.sv =====
// collects channel bytes into colour triples and numbers them within a frame
// depends on dmx_pm_pkg

module dmx_pm_assembler
  import dmx_pm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_data,
  output logic       triple_valid,
  input  logic       triple_take,
  output triple_t    triple
);

  logic [1:0] byte_phase;
  logic [1:0] byte_phase_next;
  logic [7:0] held_red;
  logic [7:0] held_green;
  logic [9:0] next_pixel;
  logic       frame_done;

  logic [1:0] phase_eff;
  logic [9:0] pixel_eff;
  logic       done_eff;
  logic       accept;
  logic       complete;

  assign byte_stall = triple_valid && !triple_take;
  assign accept     = byte_valid && !byte_stall;

  // a frame start clears the counters before the byte is placed
  assign phase_eff = byte_data.frame_start ? 2'd0  : byte_phase;
  assign pixel_eff = byte_data.frame_start ? 10'd0 : next_pixel;
  assign done_eff  = byte_data.frame_start ? 1'b0  : frame_done;
  assign complete  = (phase_eff != 2'd0) && (phase_eff != 2'd1);

  always_comb begin
    unique case (phase_eff)
      2'd0:    byte_phase_next = 2'd1;
      2'd1:    byte_phase_next = 2'd2;
      default: byte_phase_next = 2'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase   <= 2'd0;
      held_red     <= 8'd0;
      held_green   <= 8'd0;
      next_pixel   <= 10'd0;
      frame_done   <= 1'b0;
      triple_valid <= 1'b0;
    end else begin
      if (accept) begin
        byte_phase <= byte_phase_next;
        if (phase_eff == 2'd0) begin
          held_red <= byte_data.channel_byte;
        end
        if (phase_eff == 2'd1) begin
          held_green <= byte_data.channel_byte;
        end
        if (complete) begin
          next_pixel <= (pixel_eff == 10'h3FF) ? pixel_eff : pixel_eff + 10'd1;
          frame_done <= 1'b1;
        end else begin
          next_pixel <= pixel_eff;
          frame_done <= done_eff;
        end
      end
      if (accept && complete) begin
        triple_valid <= 1'b1;
      end else if (triple_take) begin
        triple_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && complete) begin
      triple.index <= pixel_eff;
      triple.first <= !done_eff;
      triple.red   <= held_red;
      triple.green <= held_green;
      triple.blue  <= byte_data.channel_byte;
    end
  end

endmodule

// ===== sv/dmx_pm_range.sv =====
// turns one colour triple into a pixel range write and holds it for the sink
// depends on dmx_pm_pkg

module dmx_pm_range
  import dmx_pm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        triple_valid,
  output logic        triple_take,
  input  triple_t     triple,
  output logic        write_valid,
  input  logic        write_stall,
  output write_item_t write_data
);

  localparam logic [9:0] LEN_MAX = 10'(MAX_PIXELS);

  logic [9:0]  len;
  logic [7:0]  gs;
  logic [17:0] group_start;
  logic [9:0]  group_rem;
  logic        emit;
  logic [8:0]  start;
  logic [9:0]  count;

  assign len = (cfg.led_count > LEN_MAX) ? LEN_MAX : cfg.led_count;
  assign gs  = (cfg.group_size == 8'd0) ? 8'd1 : cfg.group_size;

  // first pixel of the group and what is left of the strip from there
  assign group_start = {8'd0, triple.index} * {10'd0, gs};
  assign group_rem   = len - group_start[9:0];

  always_comb begin
    emit  = 1'b0;
    start = 9'd0;
    count = 10'd0;
    if (cfg.strip_enabled && (len != 10'd0)) begin
      unique case (cfg.mode)
        MODE_PIXEL: begin
          emit  = triple.index < len;
          start = triple.index[8:0];
          count = 10'd1;
        end
        MODE_GROUP: begin
          emit  = group_start < {8'd0, len};
          start = group_start[8:0];
          count = (group_rem < {2'd0, gs}) ? group_rem : {2'd0, gs};
        end
        MODE_BAR: begin
          emit  = triple.first;
          start = 9'd0;
          count = len;
        end
        MODE_IGNORE: emit = 1'b0;
        default: emit = 1'b0;
      endcase
    end
  end

  assign triple_take = triple_valid && !(write_valid && write_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      write_valid <= 1'b0;
    end else if (triple_take) begin
      write_valid <= emit;
    end else if (!write_stall) begin
      write_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (triple_take) begin
      write_data.start_index <= start;
      write_data.pixel_count <= count;
      write_data.red         <= triple.red;
      write_data.green       <= triple.green;
      write_data.blue        <= triple.blue;
    end
  end

endmodule

// ===== sv/dmx_pixel_mapper.sv =====
// dmx pixel mapper top level: register file, triple assembler, range stage
// depends on dmx_pm_pkg, dmx_pm_regs, dmx_pm_assembler, dmx_pm_range

// Takes one DMX channel byte per transfer on the byte channel; frame_start
// marks channel zero and restarts the triple count. Every third byte
// completes a red/green/blue triple, and each triple yields at most one
// transfer on the write channel: a start pixel, a pixel count and the
// colour. Mode per pixel writes pixel k for triple k, grouped mode writes
// group_size pixels from k*group_size clipped to the strip (size zero acts
// as one), whole-bar mode paints the full strip from the first triple of a
// frame only, and the ignore mode and a disabled strip produce nothing while
// still counting bytes. led_count saturates at the 512-pixel store size.
// A byte can be taken in every cycle in which byte_stall is low. There are
// two register stages: the triple register in the assembler and the result
// register in the range stage, passed in that order on the way to the write
// channel, and the byte side keeps moving while a result waits on a stalled
// sink until both stages are full. Configuration goes over the apb-style
// port (strip_enabled at 0x0, mode 0x4, led_count 0x8, group_size 0xc),
// always ready, and should be changed only while the block is idle.

module dmx_pixel_mapper
  import dmx_pm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // channel bytes in
  input  logic              byte_valid,
  output logic              byte_stall,
  input  byte_item_t        byte_data,
  // pixel range writes out
  output logic              write_valid,
  input  logic              write_stall,
  output write_item_t       write_data
);

  cfg_t    cfg;
  triple_t triple;
  logic    triple_valid;
  logic    triple_take;

  // register file, written on the access phase of a write transfer
  dmx_pm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // byte phase, held colours and the triple index within the frame
  dmx_pm_assembler u_assembler (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .triple_valid (triple_valid),
    .triple_take  (triple_take),
    .triple       (triple)
  );

  // mode decode, group multiply and clipping, then the result register
  dmx_pm_range u_range (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .triple_valid (triple_valid),
    .triple_take  (triple_take),
    .triple       (triple),
    .write_valid  (write_valid),
    .write_stall  (write_stall),
    .write_data   (write_data)
  );

endmodule

// ===== dv/tb_dmx_pixel_mapper.sv =====
// self-checking testbench for dmx_pixel_mapper: directed table, long frame, random frames
// depends on dmx_pm_pkg and the dmx_pixel_mapper rtl; uses a local model of the mapping
`timescale 1ns / 100ps

module tb_dmx_pixel_mapper;
  import dmx_pm_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;     // two register stages plus margin
  localparam int RANDOM_BYTES  = 650;
  localparam int LONG_TRIPLES  = 40;    // runs well past the end of a short strip
  localparam int LONG_LEDS     = 32;

  typedef enum logic [1:0] {
    ROW_BYTE,        // send a byte, result comes from the predictor
    ROW_WANT_WRITE,  // send a byte, result typed into the table
    ROW_WANT_NONE,   // send a byte, no result allowed
    ROW_CONFIG       // wait for idle, then write a register
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [31:0] value;
    byte_item_t  item;
    write_item_t want;
  } row_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              byte_valid = 1'b0;
  logic              byte_stall;
  byte_item_t        byte_data = '0;
  logic              write_valid;
  logic              write_stall = 1'b0;
  write_item_t       write_data;

  dmx_pixel_mapper u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_data   (byte_data),
    .write_valid (write_valid),
    .write_stall (write_stall),
    .write_data  (write_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run bookkeeping
  int unsigned cycles = 0;
  int          errors = 0;
  int          send_mode = 1;   // 0 back to back, 1 short gaps, 2 short and long gaps
  int          sink_mode = 1;   // same scale for write_stall
  int          stall_run = 0;

  // predictor copy of the register file
  bit          en_q = 1'b0;
  mode_t       mode_q = MODE_PIXEL;
  int unsigned leds_q = 0;
  int unsigned group_q = 1;

  // predictor copy of the triple assembler
  logic [1:0]  phase_q = '0;
  logic [7:0]  red_q = '0;
  logic [7:0]  green_q = '0;
  int unsigned triple_idx = 0;
  bit          frame_seen = 1'b0;

  write_item_t pending_writes[$];

  // directed table: reset state, extremes, mid-triple restart, whole bar, grouping
  row_t directed_rows [34] = '{
    // bytes before any frame start, strip still disabled after reset
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'h11, 1'b0}, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'h22, 1'b0}, '0},
    '{ROW_WANT_NONE,  REG_MODE, 32'd0, '{8'h33, 1'b0}, '0},
    // per pixel on a saturated strip
    '{ROW_CONFIG, REG_STRIP_ENABLED, 32'd1,    '0, '0},
    '{ROW_CONFIG, REG_MODE,          32'(MODE_PIXEL), '0, '0},
    '{ROW_CONFIG, REG_LED_COUNT,     32'd1023, '0, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'hFF, 1'b1}, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'h00, 1'b0}, '0},
    '{ROW_WANT_WRITE, REG_MODE, 32'd0, '{8'hFF, 1'b0}, '{9'd0, 10'd1, 8'hFF, 8'h00, 8'hFF}},
    // frame start in the middle of a triple drops the partial triple
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'h12, 1'b0}, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'hAB, 1'b1}, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'hCD, 1'b0}, '0},
    '{ROW_WANT_WRITE, REG_MODE, 32'd0, '{8'hEF, 1'b0}, '{9'd0, 10'd1, 8'hAB, 8'hCD, 8'hEF}},
    // whole bar: first triple paints all 512, the next one is dropped
    '{ROW_CONFIG, REG_MODE, 32'(MODE_BAR), '0, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'h01, 1'b1}, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'h02, 1'b0}, '0},
    '{ROW_WANT_WRITE, REG_MODE, 32'd0, '{8'h03, 1'b0}, '{9'd0, 10'd512, 8'h01, 8'h02, 8'h03}},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'h04, 1'b0}, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'h05, 1'b0}, '0},
    '{ROW_WANT_NONE,  REG_MODE, 32'd0, '{8'h06, 1'b0}, '0},
    // grouped with a zero group size acts as one pixel per triple
    '{ROW_CONFIG, REG_MODE,       32'(MODE_GROUP), '0, '0},
    '{ROW_CONFIG, REG_GROUP_SIZE, 32'd0,      '0, '0},
    '{ROW_CONFIG, REG_LED_COUNT,  32'd3,      '0, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'h80, 1'b1}, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'h7F, 1'b0}, '0},
    '{ROW_WANT_WRITE, REG_MODE, 32'd0, '{8'h55, 1'b0}, '{9'd0, 10'd1, 8'h80, 8'h7F, 8'h55}},
    // widest group, second group clipped at the end of the strip
    '{ROW_CONFIG, REG_GROUP_SIZE, 32'd255, '0, '0},
    '{ROW_CONFIG, REG_LED_COUNT,  32'd300, '0, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'hAA, 1'b1}, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'h55, 1'b0}, '0},
    '{ROW_WANT_WRITE, REG_MODE, 32'd0, '{8'h0F, 1'b0}, '{9'd0, 10'd255, 8'hAA, 8'h55, 8'h0F}},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'hF0, 1'b0}, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'h3C, 1'b0}, '0},
    '{ROW_BYTE,       REG_MODE, 32'd0, '{8'hC3, 1'b0}, '0}
  };

  task automatic report_mismatch(input string msg);
    $display("cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // local model of the mapping; returns 1 when the byte completes a triple that writes
  function automatic bit map_byte(input byte_item_t it, output write_item_t w);
    int unsigned t, len, gs, s, cnt;
    bit first, hit;
    w = '0;
    hit = 1'b0;
    s = 0;
    cnt = 0;
    if (it.frame_start) begin
      phase_q = '0;
      triple_idx = 0;
      frame_seen = 1'b0;
    end
    if (phase_q == 2'd0) begin
      red_q = it.channel_byte;
      phase_q = 2'd1;
      return 1'b0;
    end
    if (phase_q == 2'd1) begin
      green_q = it.channel_byte;
      phase_q = 2'd2;
      return 1'b0;
    end
    // third byte closes the triple
    phase_q = 2'd0;
    t = triple_idx;
    first = !frame_seen;
    if (triple_idx < 1023) triple_idx++;
    frame_seen = 1'b1;
    len = (leds_q > MAX_PIXELS) ? MAX_PIXELS : leds_q;
    if (en_q && len > 0) begin
      case (mode_q)
        MODE_PIXEL: begin
          if (t < len) begin
            s = t;
            cnt = 1;
            hit = 1'b1;
          end
        end
        MODE_GROUP: begin
          gs = (group_q == 0) ? 1 : group_q;
          s = t * gs;
          if (s < len) begin
            cnt = (len - s < gs) ? len - s : gs;
            hit = 1'b1;
          end
        end
        MODE_BAR: begin
          if (first) begin
            s = 0;
            cnt = len;
            hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
    w.start_index = s[8:0];
    w.pixel_count = cnt[9:0];
    w.red         = red_q;
    w.green       = green_q;
    w.blue        = it.channel_byte;
    return hit;
  endfunction

  task automatic note_byte(input byte_item_t it);
    write_item_t w;
    if (map_byte(it, w)) pending_writes.push_back(w);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (send_mode == 0 || roll < 60) return 0;
    if (send_mode == 1 || roll < 90) return $urandom_range(4, 1);
    return $urandom_range(40, 8);
  endfunction

  // leaves byte_valid high after the transfer; the caller sends again or lowers it
  task automatic send_byte(input byte_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= it;
    do @(posedge clk); while (byte_stall !== 1'b0);
  endtask

  // stop sending, let every expected write drain, then let the pipeline settle
  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup phase, access phase, then the port is left idle
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_STRIP_ENABLED: en_q    = value[0];
      REG_MODE:          mode_q  = mode_t'(value[1:0]);
      REG_LED_COUNT:     leds_q  = value[9:0];
      REG_GROUP_SIZE:    group_q = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cmp_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic check_write(input write_item_t got);
    write_item_t want;
    if (pending_writes.size() == 0) begin
      report_mismatch($sformatf("write with nothing pending: %h", got));
      return;
    end
    want = pending_writes.pop_front();
    cmp_field("start_index", got.start_index, want.start_index);
    cmp_field("pixel_count", got.pixel_count, want.pixel_count);
    cmp_field("red", got.red, want.red);
    cmp_field("green", got.green, want.green);
    cmp_field("blue", got.blue, want.blue);
  endtask

  // write side: compare every accepted transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && write_valid === 1'b1 && write_stall == 1'b0) check_write(write_data);
  end

  // sink back-pressure: off, short runs, or short runs with the odd long one
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run   <= stall_run - 1;
      write_stall <= 1'b1;
    end else if (sink_mode != 0 && $urandom_range(99) < 25) begin
      write_stall <= 1'b1;
      if (sink_mode == 2 && $urandom_range(9) == 0) stall_run <= $urandom_range(40, 10);
      else stall_run <= $urandom_range(3, 0);
    end else begin
      write_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dmx_pixel_mapper test failed");
      $finish;
    end
  end

  initial begin
    row_t        r;
    write_item_t scratch;
    byte_item_t  it;
    int          sent, phase, n;
    logic [31:0] v;
    sent  = 0;
    phase = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      case (r.kind)
        ROW_CONFIG: begin
          wait_idle();
          reg_write(r.idx, r.value);
        end
        ROW_BYTE: begin
          send_byte(r.item);
          note_byte(r.item);
        end
        default: begin
          send_byte(r.item);
          void'(map_byte(r.item, scratch));
          if (r.kind == ROW_WANT_WRITE) pending_writes.push_back(r.want);
        end
      endcase
    end

    // one back-to-back frame that runs off the end of a short strip
    wait_idle();
    reg_write(REG_MODE, 32'(MODE_PIXEL));
    reg_write(REG_LED_COUNT, 32'(LONG_LEDS));
    send_mode = 0;
    for (int k = 0; k < 3 * LONG_TRIPLES; k++) begin
      it.channel_byte = 8'($urandom_range(255));
      it.frame_start  = (k == 0);
      send_byte(it);
      note_byte(it);
    end

    // random phases: new settings, then mostly well-formed frames with some noise
    while (sent < RANDOM_BYTES) begin
      wait_idle();
      reg_write(REG_STRIP_ENABLED, 32'($urandom_range(9) != 0));
      reg_write(REG_MODE, (phase < 4) ? phase : $urandom_range(3));
      case ($urandom_range(5))
        0:       v = 32'd512;
        1:       v = 32'd1023;
        2:       v = $urandom_range(1023);
        default: v = $urandom_range(24, 1);
      endcase
      if (phase == 0) v = 32'd0;
      reg_write(REG_LED_COUNT, v);
      case ($urandom_range(4))
        0:       v = 32'd0;
        1:       v = 32'd255;
        2:       v = $urandom_range(255);
        default: v = $urandom_range(6, 1);
      endcase
      reg_write(REG_GROUP_SIZE, v);
      send_mode = $urandom_range(2);
      sink_mode = $urandom_range(2);
      phase++;

      repeat ($urandom_range(4, 1)) begin
        if ($urandom_range(9) < 8) begin
          // well-formed frame of whole triples
          n = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
          for (int k = 0; k < 3 * n; k++) begin
            it.channel_byte = 8'($urandom_range(255));
            it.frame_start  = (k == 0);
            send_byte(it);
            note_byte(it);
            sent++;
          end
        end else begin
          // broken run: stray frame starts and partial triples
          n = $urandom_range(10, 1);
          for (int k = 0; k < n; k++) begin
            it.channel_byte = 8'($urandom_range(255));
            it.frame_start  = ($urandom_range(2) == 0);
            send_byte(it);
            note_byte(it);
            sent++;
          end
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("dmx_pixel_mapper test passed");
    end else begin
      $display("dmx_pixel_mapper test failed");
    end
    $finish;
  end

endmodule
